>>> rtl/uevd_pkg.sv
// Package with the shared types, constants and helper functions of the Unicode escape decoder.
package uevd_pkg;

    localparam int BURST_MAX = 6;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam int BCNT_W    = $clog2(BURST_MAX + 1);

    localparam logic [7:0] CH_BS = 8'h5C;
    localparam logic [7:0] CH_U  = 8'h75;

    localparam logic [15:0] SURR_LO = 16'hD800;
    localparam logic [15:0] SURR_HI = 16'hDFFF;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_BS   = 3'd1;
    localparam logic [2:0] PH_U    = 3'd2;
    localparam logic [2:0] PH_D1   = 3'd3;
    localparam logic [2:0] PH_D2   = 3'd4;
    localparam logic [2:0] PH_D3   = 3'd5;

    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] data;
        logic [BCNT_W-1:0]         cnt;
    } t_burst;

    typedef struct packed {
        t_burst burst;
        logic   fin;
    } t_qent;

    function automatic logic f_is_hex(input logic [7:0] c);
        f_is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
                   (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] f_hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end
        f_hex_val = v[3:0];
    endfunction

    function automatic t_burst f_put(input t_burst b, input logic [7:0] v);
        t_burst r;
        r = b;
        r.data[r.cnt] = v;
        r.cnt = r.cnt + BCNT_W'(1);
        f_put = r;
    endfunction

    // Sends out the backslash and whatever characters of the escape are held.
    function automatic t_burst f_flush(input t_burst b, input logic [2:0] p,
                                       input logic [2:0][7:0] d);
        t_burst r;
        r = f_put(b, CH_BS);
        if (p >= PH_U) begin
            r = f_put(r, CH_U);
            for (int j = 0; j < 3; j++) begin
                if (3'(j) < p - PH_U) begin
                    r = f_put(r, d[j]);
                end
            end
        end
        f_flush = r;
    endfunction

endpackage

>>> rtl/uevd_in_if.sv
// Interface of the input channel: one text character and its end-of-value flag.
interface uevd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_final;

    modport source (output valid, output in_char, output in_final, input ready);
    modport sink   (input valid, input in_char, input in_final, output ready);
endinterface

>>> rtl/uevd_out_if.sv
// Interface of the output channel: one decoded byte with its run and value markers.
interface uevd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       value_last;

    modport source (output valid, output out_byte, output run_last, output value_last,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input value_last,
                    output ready);
endinterface

>>> rtl/unicode_escape_value_decoder_core.sv
// Top level of the Unicode escape decoder: front end, burst queue and output sequencer.
// The input channel takes one character of a text value per transfer, with in_final
// set on the last character. Backslash-backslash and backslash-u with four hex digits
// are decoded; a failed escape is sent out as it came. The output channel gives one
// byte per transfer, run_last on the last byte caused by an input character and
// value_last on the last byte of the value. A character that only extends a pending
// escape produces no output transfer.
// Throughput: one input character per cycle while the queue has room; the output side
// moves one byte per cycle while the receiver is ready, and the four-entry burst queue
// absorbs the bursts of characters that yield several bytes.
// With the queue empty and the output sequencer idle, the first byte of a character is
// written into the queue at its input transfer, loaded from there into the output
// sequencer's registers, and only then valid on the output.
// Reset clears the escape state, empties the queue and drops o_out.valid.
// When the receiver stalls, the current byte holds, the queue fills, and after four
// waiting bursts i_in.ready falls until the output drains.
module unicode_escape_value_decoder_core (
    input  logic  i_clk,
    input  logic  i_rst_n,
    uevd_in_if.sink    i_in,
    uevd_out_if.source o_out
);
    import uevd_pkg::*;

    logic  full;
    logic  push;
    t_qent ent;
    logic  pop;
    logic  head_valid;
    t_qent head;

    uevd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_ent   (ent)
    );

    uevd_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_ent        (ent),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    uevd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

>>> rtl/uevd_front.sv
// Front end: accepts characters, tracks the escape state and builds each byte burst.
module uevd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    uevd_in_if.sink        i_in,
    input  logic           i_full,
    output logic           o_push,
    output uevd_pkg::t_qent o_ent
);
    import uevd_pkg::*;

    logic [2:0]      r_phase;
    logic [2:0][7:0] r_digits;
    logic [2:0]      n_phase;
    logic [2:0][7:0] n_digits;
    t_burst          bst;
    logic [7:0]      c;
    logic            hexok;
    logic [15:0]     cp;
    logic [1:0]      dig_idx;
    logic            accept;

    assign c       = i_in.in_char;
    assign hexok   = f_is_hex(c);
    assign cp      = {f_hex_val(r_digits[0]), f_hex_val(r_digits[1]),
                      f_hex_val(r_digits[2]), f_hex_val(c)};
    assign dig_idx = 2'(r_phase - PH_U);

    always_comb begin
        bst      = '0;
        n_phase  = r_phase;
        n_digits = r_digits;
        unique case (r_phase)
            PH_BS: begin
                if (c == CH_BS) begin
                    bst     = f_put(bst, CH_BS);
                    n_phase = PH_IDLE;
                end else if (c == CH_U) begin
                    n_phase = PH_U;
                end else begin
                    bst     = f_flush(bst, r_phase, r_digits);
                    n_phase = PH_IDLE;
                    if (c == CH_BS) n_phase = PH_BS;
                    else bst = f_put(bst, c);
                end
            end
            PH_U, PH_D1, PH_D2: begin
                if (hexok) begin
                    n_digits[dig_idx] = c;
                    n_phase           = r_phase + 3'd1;
                end else begin
                    bst     = f_flush(bst, r_phase, r_digits);
                    n_phase = PH_IDLE;
                    if (c == CH_BS) n_phase = PH_BS;
                    else bst = f_put(bst, c);
                end
            end
            PH_D3: begin
                n_phase = PH_IDLE;
                if (!hexok) begin
                    bst = f_flush(bst, r_phase, r_digits);
                    if (c == CH_BS) n_phase = PH_BS;
                    else bst = f_put(bst, c);
                end else if (cp >= SURR_LO && cp <= SURR_HI) begin
                    bst = f_flush(bst, r_phase, r_digits);
                    bst = f_put(bst, c);
                end else if (cp < 16'h0080) begin
                    bst = f_put(bst, cp[7:0]);
                end else if (cp < 16'h0800) begin
                    bst = f_put(bst, {3'b110, cp[10:6]});
                    bst = f_put(bst, {2'b10, cp[5:0]});
                end else begin
                    bst = f_put(bst, {4'b1110, cp[15:12]});
                    bst = f_put(bst, {2'b10, cp[11:6]});
                    bst = f_put(bst, {2'b10, cp[5:0]});
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (c == CH_BS) n_phase = PH_BS;
                else bst = f_put(bst, c);
            end
        endcase
        if (i_in.in_final && n_phase != PH_IDLE) begin
            bst     = f_flush(bst, n_phase, n_digits);
            n_phase = PH_IDLE;
        end
    end

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;
    assign o_push     = accept && (bst.cnt != '0);
    assign o_ent      = '{burst: bst, fin: i_in.in_final};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (accept) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_digits <= n_digits;
        end
    end

endmodule

>>> rtl/uevd_fifo.sv
// Short queue of byte bursts between the front end and the output sequencer.
module uevd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  uevd_pkg::t_qent i_ent,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_head_valid,
    output uevd_pkg::t_qent o_head
);
    import uevd_pkg::*;

    t_qent             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_pop;

    assign o_full       = (r_cnt == QCNT_W'(QDEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QPTR_W'(1);
            if (do_pop) r_rd <= r_rd + QPTR_W'(1);
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(do_pop);
        end
    end

endmodule

>>> rtl/uevd_back.sv
// Back end: takes one burst from the queue and sends its bytes out one per transfer.
module uevd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  uevd_pkg::t_qent i_head,
    output logic            o_pop,
    uevd_out_if.source      o_out
);
    import uevd_pkg::*;

    t_qent             r_ent;
    logic [BCNT_W-1:0] r_idx;
    logic              r_busy;
    logic              last;

    assign last             = (r_idx == r_ent.burst.cnt - BCNT_W'(1));
    assign o_out.valid      = r_busy;
    assign o_out.out_byte   = r_ent.burst.data[r_idx];
    assign o_out.run_last   = last;
    assign o_out.value_last = last && r_ent.fin;
    assign o_pop            = i_head_valid && (!r_busy || (o_out.ready && last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && o_out.ready) begin
            if (last) r_busy <= 1'b0;
            else r_idx <= r_idx + BCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_head;
        end
    end

endmodule

>>> rtl/uevd_checker.sv
// Port-level checker for the Unicode escape decoder and its bind to the top level.
module uevd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_run_last,
    input logic       i_out_value_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) &&
        $stable(i_out_value_last))
        else $error("Output byte changed while stalled.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Output valid after reset.");

    a_value_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_value_last |-> i_out_run_last)
        else $error("End of value without end of run.");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("Input stalled while output idle.");

endmodule

bind unicode_escape_value_decoder_core uevd_checker u_uevd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_byte       (o_out.out_byte),
    .i_out_run_last   (o_out.run_last),
    .i_out_value_last (o_out.value_last)
);

>>> tb/sv/tb_unicode_escape_value_decoder_core.sv
// Self-checking testbench for the Unicode escape decoder core with directed and random text.
`timescale 1ns / 100ps

module tb_unicode_escape_value_decoder_core;
    import uevd_pkg::*;

    localparam int N_DIRECTED  = 29;
    localparam int TEXT_ITEMS  = 440;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 19;
    localparam int STALL_AT    = 120;
    localparam int STALL_LEN   = 80;
    localparam int CALM_FROM   = 250;
    localparam int CALM_TO     = 350;
    localparam int DRAIN_WAIT  = 20;

    typedef struct packed {
        logic [7:0]      ch;
        logic            fin;
        logic            typed;
        logic [2:0]      n;
        logic [0:5][7:0] b;
    } t_row;

    typedef struct packed {
        logic [7:0] octet;
        logic       run_last;
        logic       value_last;
    } t_res;

    // Rows with a typed result are checked against it; the others against the decoder model.
    localparam t_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{8'h00, 1'b1, 1'b1, 3'd1, {8'h00, 40'h0}},
        '{CH_BS, 1'b0, 1'b1, 3'd0, 48'h0},
        '{CH_BS, 1'b0, 1'b1, 3'd1, {8'h5C, 40'h0}},
        '{CH_BS, 1'b0, 1'b1, 3'd0, 48'h0},
        '{8'hFF, 1'b0, 1'b1, 3'd2, {8'h5C, 8'hFF, 32'h0}},
        '{CH_BS, 1'b0, 1'b0, 3'd0, 48'h0},
        '{CH_U,  1'b0, 1'b0, 3'd0, 48'h0},
        '{8'h30, 1'b0, 1'b0, 3'd0, 48'h0},
        '{8'h30, 1'b0, 1'b0, 3'd0, 48'h0},
        '{8'h30, 1'b0, 1'b0, 3'd0, 48'h0},
        '{8'h30, 1'b0, 1'b1, 3'd1, {8'h00, 40'h0}},
        '{CH_BS, 1'b0, 1'b0, 3'd0, 48'h0},
        '{CH_U,  1'b0, 1'b0, 3'd0, 48'h0},
        '{8'h46, 1'b0, 1'b0, 3'd0, 48'h0},
        '{8'h46, 1'b0, 1'b0, 3'd0, 48'h0},
        '{8'h66, 1'b0, 1'b0, 3'd0, 48'h0},
        '{8'h46, 1'b0, 1'b1, 3'd3, {8'hEF, 8'hBF, 8'hBF, 24'h0}},
        '{CH_BS, 1'b0, 1'b0, 3'd0, 48'h0},
        '{CH_U,  1'b0, 1'b0, 3'd0, 48'h0},
        '{8'h44, 1'b0, 1'b0, 3'd0, 48'h0},
        '{8'h38, 1'b0, 1'b0, 3'd0, 48'h0},
        '{8'h30, 1'b0, 1'b0, 3'd0, 48'h0},
        '{8'h30, 1'b0, 1'b1, 3'd6, {8'h5C, 8'h75, 8'h44, 8'h38, 8'h30, 8'h30}},
        '{CH_BS, 1'b0, 1'b0, 3'd0, 48'h0},
        '{CH_U,  1'b0, 1'b0, 3'd0, 48'h0},
        '{8'h31, 1'b0, 1'b0, 3'd0, 48'h0},
        '{8'h67, 1'b0, 1'b1, 3'd4, {8'h5C, 8'h75, 8'h31, 8'h67, 16'h0}},
        '{CH_BS, 1'b0, 1'b0, 3'd0, 48'h0},
        '{CH_U,  1'b1, 1'b1, 3'd2, {8'h5C, 8'h75, 32'h0}}
    };

    logic i_clk;
    logic i_rst_n;

    uevd_in_if  in_ch ();
    uevd_out_if out_ch ();

    unicode_escape_value_decoder_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [2:0] esc_phase;
    logic [7:0] esc_digits [3];
    t_res       step_bytes [$];
    t_res       decoded_q [$];
    t_row       chars_offered [$];
    t_row       text_q [$];
    int         chars_taken;
    int         mismatches;
    int         cycles;
    bit         stall_done;

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function automatic void emit(input logic [7:0] b);
        step_bytes.insert(step_bytes.size(), '{b, 1'b0, 1'b0});
    endfunction

    function automatic void flush_escape();
        emit(CH_BS);
        if (esc_phase >= PH_U) begin
            emit(CH_U);
            for (int k = 0; k < int'(esc_phase - PH_U) && k < 3; k++) begin
                emit(esc_digits[k]);
            end
        end
        esc_phase = PH_IDLE;
    endfunction

    function automatic void read_fresh(input logic [7:0] c);
        if (c == CH_BS) begin
            esc_phase = PH_BS;
        end else begin
            emit(c);
        end
    endfunction

    function automatic void decode_char(input logic [7:0] c, input logic fin);
        logic [15:0] cp;
        int          hv;
        step_bytes.delete();
        hv = hex_nibble(c);
        case (esc_phase)
            PH_BS: begin
                if (c == CH_BS) begin
                    emit(CH_BS);
                    esc_phase = PH_IDLE;
                end else if (c == CH_U) begin
                    esc_phase = PH_U;
                end else begin
                    flush_escape();
                    read_fresh(c);
                end
            end
            PH_U, PH_D1, PH_D2: begin
                if (hv >= 0) begin
                    esc_digits[esc_phase - PH_U] = c;
                    esc_phase = esc_phase + 3'd1;
                end else begin
                    flush_escape();
                    read_fresh(c);
                end
            end
            PH_D3: begin
                if (hv < 0) begin
                    flush_escape();
                    read_fresh(c);
                end else begin
                    cp = {4'(hex_nibble(esc_digits[0])), 4'(hex_nibble(esc_digits[1])),
                          4'(hex_nibble(esc_digits[2])), 4'(hv)};
                    if (cp >= SURR_LO && cp <= SURR_HI) begin
                        flush_escape();
                        emit(c);
                    end else if (cp < 16'h0080) begin
                        emit(cp[7:0]);
                    end else if (cp < 16'h0800) begin
                        emit({3'b110, cp[10:6]});
                        emit({2'b10, cp[5:0]});
                    end else begin
                        emit({4'hE, cp[15:12]});
                        emit({2'b10, cp[11:6]});
                        emit({2'b10, cp[5:0]});
                    end
                    esc_phase = PH_IDLE;
                end
            end
            default: begin
                esc_phase = PH_IDLE;
                read_fresh(c);
            end
        endcase
        if (fin && esc_phase != PH_IDLE) begin
            flush_escape();
        end
        if (step_bytes.size() > 0) begin
            step_bytes[step_bytes.size() - 1].run_last   = 1'b1;
            step_bytes[step_bytes.size() - 1].value_last = fin;
        end
    endfunction

    function automatic void add_char(input logic [7:0] c);
        text_q.insert(text_q.size(), '{c, 1'b0, 1'b0, 3'd0, 48'h0});
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + 8'(v);
        if ($urandom_range(0, 1) == 0) return 8'h61 + 8'(v) - 8'd10;
        return 8'h41 + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (hex_nibble(c) >= 0) begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // One value: mostly well-formed escapes and plain text, some broken or cut-off escapes.
    function automatic void add_value();
        int          ntok;
        int          roll;
        int          ndig;
        logic [15:0] cp;
        logic [7:0]  c;
        bit          cut;
        ntok = $urandom_range(1, 8);
        cut  = 1'b0;
        for (int t = 0; t < ntok && !cut; t++) begin
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
                c = 8'($urandom_range(0, 255));
                add_char(c == CH_BS ? 8'h61 : c);
            end else if (roll < 65) begin
                case ($urandom_range(0, 3))
                    0: cp = 16'($urandom_range(0, 'h7F));
                    1: cp = 16'($urandom_range('h80, 'h7FF));
                    2: cp = 16'($urandom_range('h800, 'hFFFF));
                    default: cp = 16'($urandom_range('hD800, 'hDFFF));
                endcase
                add_char(CH_BS);
                add_char(CH_U);
                add_char(hex_char(cp[15:12]));
                add_char(hex_char(cp[11:8]));
                add_char(hex_char(cp[7:4]));
                add_char(hex_char(cp[3:0]));
            end else if (roll < 75) begin
                add_char(CH_BS);
                add_char(CH_BS);
            end else if (roll < 93) begin
                add_char(CH_BS);
                if ($urandom_range(0, 2) == 0) begin
                    c = 8'($urandom_range(0, 255));
                    add_char(c == CH_U ? 8'h76 : c);
                end else begin
                    add_char(CH_U);
                    ndig = $urandom_range(0, 3);
                    for (int k = 0; k < ndig; k++) begin
                        add_char(hex_char(4'($urandom_range(0, 15))));
                    end
                    add_char($urandom_range(0, 3) == 0 ? CH_BS : non_hex_char());
                end
            end else begin
                add_char(CH_BS);
                if ($urandom_range(0, 1) == 1) begin
                    add_char(CH_U);
                    ndig = $urandom_range(0, 3);
                    for (int k = 0; k < ndig; k++) begin
                        add_char(hex_char(4'($urandom_range(0, 15))));
                    end
                end
                cut = 1'b1;
            end
        end
        text_q[text_q.size() - 1].fin = 1'b1;
    endfunction

    function automatic bit calm();
        return chars_taken >= CALM_FROM && chars_taken < CALM_TO;
    endfunction

    task automatic send_row(input t_row r);
        while (!calm() && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        chars_offered.insert(chars_offered.size(), r);
        in_ch.valid    <= 1'b1;
        in_ch.in_char  <= r.ch;
        in_ch.in_final <= r.fin;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string why, input t_res want, input t_res got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: expected byte %h run_last %b value_last %b,", why,
                     want.octet, want.run_last, want.value_last,
                     " got byte %h run_last %b value_last %b",
                     got.octet, got.run_last, got.value_last);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("unicode_escape_value_decoder_core verification failed");
        $finish;
    end

    always @(posedge i_clk) begin : track
        t_row r;
        t_res got;
        t_res want;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            r = chars_offered.pop_front();
            decode_char(r.ch, r.fin);
            if (r.typed) begin
                step_bytes.delete();
                for (int k = 0; k < int'(r.n); k++) begin
                    step_bytes.insert(step_bytes.size(),
                                      '{r.b[k], k == int'(r.n) - 1,
                                        r.fin && k == int'(r.n) - 1});
                end
            end
            foreach (step_bytes[k]) begin
                decoded_q.insert(decoded_q.size(), step_bytes[k]);
            end
            chars_taken++;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.out_byte, out_ch.run_last, out_ch.value_last};
            if (decoded_q.size() == 0) begin
                report_mismatch("unexpected transfer", '0, got);
            end else begin
                want = decoded_q.pop_front();
                if (want.octet !== got.octet || want.run_last !== got.run_last ||
                    want.value_last !== got.value_last) begin
                    report_mismatch("output mismatch", want, got);
                end
            end
        end
    end

    initial begin
        out_ch.ready <= 1'b0;
        stall_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!stall_done && chars_taken >= STALL_AT) begin
                stall_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (STALL_LEN) @(negedge i_clk);
            end else begin
                out_ch.ready <= calm() || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.in_char  <= 8'h00;
        in_ch.in_final <= 1'b0;
        esc_phase   = PH_IDLE;
        esc_digits  = '{8'h00, 8'h00, 8'h00};
        chars_taken = 0;
        mismatches  = 0;
        while (text_q.size() < TEXT_ITEMS) begin
            add_value();
        end
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_row(DIRECTED_ROWS[i]);
        end
        foreach (text_q[i]) begin
            send_row(text_q[i]);
        end
        in_ch.valid <= 1'b0;
        while (decoded_q.size() != 0 || chars_offered.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("unicode_escape_value_decoder_core verification clean");
        end else begin
            $display("unicode_escape_value_decoder_core verification failed");
        end
        $finish;
    end

endmodule
